// ----- hw/rtl/ecb_pkg.sv -----
package ecb_pkg;

    localparam int NUM_SITES   = 1024;
    localparam int MAX_CLASSES = 32;

    localparam int ATOM_W   = $clog2(NUM_SITES);
    localparam int SLOT_W   = ATOM_W;
    localparam int CNT_W    = $clog2(NUM_SITES + 1);
    localparam int CLS_W    = $clog2(MAX_CLASSES);
    localparam int CIU_W    = $clog2(MAX_CLASSES + 1);
    localparam int ACP_W    = CIU_W;
    localparam int MEM_AW   = CLS_W + ATOM_W;
    localparam int SITE_W   = 16;
    localparam int EN_W     = 16;
    localparam int TOL_W    = 15;
    localparam int CFG_IW   = 1;
    localparam int CFG_DW   = 16;
    localparam int TOL_RESET = 64;

    typedef enum logic [CFG_IW-1:0] {
        REG_TOLERANCE   = 1'b0,
        REG_SITE_OFFSET = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_MOVE   = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TABLE_FULL  = 3'd1,
        ST_NOT_PRESENT = 3'd2,
        ST_OUT_OF_RANGE = 3'd3,
        ST_ALREADY     = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WAIT,
        S_CHK,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_REM_A,
        S_REM_B,
        S_REM_C,
        S_ADD_A,
        S_ADD_B,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [CLS_W-1:0]  cls;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  count;
        logic              opened;
        t_status           status;
    } t_result;

    typedef struct packed {
        logic    clr_step;
        logic    take;
        logic    chk;
        logic    srch_start;
        logic    srch_next;
        logic    hit;
        logic    miss;
        logic    sz_sel_new;
        logic    rm_rd_last;
        logic    rm_wr;
        logic    add_wr;
        logic    res_zero;
        logic    res_err;
        t_status err_code;
        logic    out_load;
    } t_ctl;

    typedef struct packed {
        logic clr_last;
        t_cmd cmd;
        logic rng_bad;
        logic present;
        logic match;
        logic srch_end;
        logic full;
        logic out_free;
    } t_stat;

endpackage

// ----- hw/rtl/ecb_ram.sv -----
module ecb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/ecb_datapath.sv -----
module ecb_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [ecb_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [ecb_pkg::CFG_DW-1:0]   i_cfg_data,
    input  logic [1:0]                   i_cmd,
    input  logic [ecb_pkg::SITE_W-1:0]   i_site_number,
    input  logic signed [ecb_pkg::EN_W-1:0] i_site_energy,
    input  ecb_pkg::t_ctl                i_ctl,
    output ecb_pkg::t_stat               o_stat,
    input  logic                         i_ready,
    output logic                         o_valid,
    output logic [4:0]                   o_class_index,
    output logic [9:0]                   o_slot_index,
    output logic [10:0]                  o_class_count,
    output logic                         o_new_class,
    output logic [2:0]                   o_status
);

    logic [ecb_pkg::TOL_W-1:0]  r_tol;
    logic [ecb_pkg::SITE_W-1:0] r_off;
    ecb_pkg::t_cmd              r_cmd;
    logic signed [ecb_pkg::EN_W-1:0] r_energy;
    logic [ecb_pkg::ATOM_W-1:0] r_atom;
    logic                       r_rng_bad;
    logic [ecb_pkg::CLS_W-1:0]  r_oldc;
    logic [ecb_pkg::SLOT_W-1:0] r_olds;
    logic [ecb_pkg::CNT_W-1:0]  r_k;
    logic [ecb_pkg::CIU_W-1:0]  r_idx;
    logic [ecb_pkg::CLS_W-1:0]  r_c;
    logic                       r_opened;
    logic [ecb_pkg::CIU_W-1:0]  r_ciu;
    logic [ecb_pkg::ATOM_W-1:0] r_clr_idx;
    ecb_pkg::t_result           r_res;
    ecb_pkg::t_result           r_out;
    logic                       r_out_valid;

    logic [ecb_pkg::SITE_W:0]   diff;
    logic                       rng_bad;

    logic [ecb_pkg::ACP_W-1:0]  acp_rdata, acp_wdata;
    logic [ecb_pkg::ATOM_W-1:0] acp_waddr;
    logic                       acp_we;
    logic [ecb_pkg::SLOT_W-1:0] slot_rdata, slot_wdata;
    logic [ecb_pkg::ATOM_W-1:0] slot_waddr;
    logic                       slot_we;
    logic [ecb_pkg::CNT_W-1:0]  size_rdata, size_wdata;
    logic [ecb_pkg::CLS_W-1:0]  size_raddr, size_waddr;
    logic                       size_we;
    logic [ecb_pkg::SLOT_W-1:0] mem_rdata, mem_wdata;
    logic [ecb_pkg::MEM_AW-1:0] mem_raddr, mem_waddr;
    logic                       mem_we;
    logic signed [ecb_pkg::EN_W-1:0] en_rdata;

    logic [ecb_pkg::SLOT_W-1:0] last;
    logic [ecb_pkg::CNT_W-1:0]  k_new;
    logic [ecb_pkg::SLOT_W-1:0] s_new;
    logic [ecb_pkg::CNT_W-1:0]  cnt_new;
    logic [ecb_pkg::CNT_W-1:0]  cnt_rm;
    logic signed [ecb_pkg::EN_W+1:0] e_x, ce_x, tol_x, lo, hi;

    assign diff    = {1'b0, i_site_number} - {1'b0, r_off};
    assign rng_bad = (i_site_number <= r_off) ||
                     (diff > (ecb_pkg::SITE_W+1)'(ecb_pkg::NUM_SITES));

    // class window compare, widened so the bounds never wrap
    assign e_x   = {{2{r_energy[ecb_pkg::EN_W-1]}}, r_energy};
    assign ce_x  = {{2{en_rdata[ecb_pkg::EN_W-1]}}, en_rdata};
    assign tol_x = {3'b000, r_tol};
    assign lo    = ce_x - tol_x;
    assign hi    = ce_x + tol_x;

    assign last    = (size_rdata == '0) ? '0 : ecb_pkg::SLOT_W'(size_rdata - 1'b1);
    assign k_new   = r_opened ? '0 : size_rdata;
    assign s_new   = k_new[ecb_pkg::SLOT_W-1:0];
    assign cnt_new = ecb_pkg::CNT_W'(s_new) + 1'b1;
    assign cnt_rm  = (r_k == '0) ? '0 : r_k - 1'b1;

    always_comb begin
        acp_we    = i_ctl.clr_step | i_ctl.rm_wr | i_ctl.add_wr;
        acp_waddr = i_ctl.clr_step ? r_clr_idx : r_atom;
        acp_wdata = i_ctl.add_wr ? ecb_pkg::ACP_W'(r_c) + 1'b1 : '0;

        slot_we    = i_ctl.rm_wr | i_ctl.add_wr;
        slot_waddr = i_ctl.rm_wr ? mem_rdata : r_atom;
        slot_wdata = i_ctl.rm_wr ? r_olds : s_new;

        size_raddr = i_ctl.sz_sel_new ? r_c : r_oldc;
        size_we    = (i_ctl.rm_wr && (r_k != '0)) | i_ctl.add_wr;
        size_waddr = i_ctl.rm_wr ? r_oldc : r_c;
        size_wdata = i_ctl.rm_wr ? cnt_rm : cnt_new;

        mem_raddr = {r_oldc, last};
        mem_we    = i_ctl.rm_wr | i_ctl.add_wr;
        mem_waddr = i_ctl.rm_wr ? {r_oldc, r_olds} : {r_c, s_new};
        mem_wdata = i_ctl.rm_wr ? mem_rdata : r_atom;
    end

    ecb_ram #(.WIDTH(ecb_pkg::ACP_W), .DEPTH(ecb_pkg::NUM_SITES)) u_acp (
        .i_clk(i_clk), .i_we(acp_we), .i_waddr(acp_waddr), .i_wdata(acp_wdata),
        .i_raddr(r_atom), .o_rdata(acp_rdata)
    );

    ecb_ram #(.WIDTH(ecb_pkg::SLOT_W), .DEPTH(ecb_pkg::NUM_SITES)) u_slot (
        .i_clk(i_clk), .i_we(slot_we), .i_waddr(slot_waddr), .i_wdata(slot_wdata),
        .i_raddr(r_atom), .o_rdata(slot_rdata)
    );

    ecb_ram #(.WIDTH(ecb_pkg::CNT_W), .DEPTH(ecb_pkg::MAX_CLASSES)) u_size (
        .i_clk(i_clk), .i_we(size_we), .i_waddr(size_waddr), .i_wdata(size_wdata),
        .i_raddr(size_raddr), .o_rdata(size_rdata)
    );

    ecb_ram #(.WIDTH(ecb_pkg::SLOT_W),
              .DEPTH(ecb_pkg::MAX_CLASSES * ecb_pkg::NUM_SITES)) u_members (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(mem_waddr), .i_wdata(mem_wdata),
        .i_raddr(mem_raddr), .o_rdata(mem_rdata)
    );

    ecb_ram #(.WIDTH(ecb_pkg::EN_W), .DEPTH(ecb_pkg::MAX_CLASSES)) u_energy (
        .i_clk(i_clk), .i_we(i_ctl.miss), .i_waddr(r_ciu[ecb_pkg::CLS_W-1:0]),
        .i_wdata(r_energy), .i_raddr(r_idx[ecb_pkg::CLS_W-1:0]), .o_rdata(en_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol       <= ecb_pkg::TOL_W'(ecb_pkg::TOL_RESET);
            r_off       <= '0;
            r_ciu       <= '0;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (ecb_pkg::t_reg_idx'(i_cfg_index))
                    ecb_pkg::REG_TOLERANCE:   r_tol <= i_cfg_data[ecb_pkg::TOL_W-1:0];
                    ecb_pkg::REG_SITE_OFFSET: r_off <= i_cfg_data[ecb_pkg::SITE_W-1:0];
                    default: ;
                endcase
            end
            if (i_ctl.clr_step) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (i_ctl.miss) begin
                r_ciu <= r_ciu + 1'b1;
            end
            if (i_ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.take) begin
            r_cmd     <= ecb_pkg::t_cmd'(i_cmd);
            r_energy  <= i_site_energy;
            r_rng_bad <= rng_bad;
            r_atom    <= ecb_pkg::ATOM_W'(diff - 1'b1);
        end
        if (i_ctl.chk) begin
            r_oldc <= ecb_pkg::CLS_W'(acp_rdata - 1'b1);
            r_olds <= slot_rdata;
        end
        if (i_ctl.srch_start) begin
            r_idx <= '0;
        end else if (i_ctl.srch_next) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_ctl.hit) begin
            r_c      <= r_idx[ecb_pkg::CLS_W-1:0];
            r_opened <= 1'b0;
        end else if (i_ctl.miss) begin
            r_c      <= r_ciu[ecb_pkg::CLS_W-1:0];
            r_opened <= 1'b1;
        end
        if (i_ctl.rm_rd_last) begin
            r_k <= size_rdata;
        end
        priority if (i_ctl.res_zero || i_ctl.res_err) begin
            r_res <= '{cls: '0, slot: '0, count: '0, opened: 1'b0,
                       status: (i_ctl.res_zero ? ecb_pkg::ST_OK : i_ctl.err_code)};
        end else if (i_ctl.add_wr) begin
            r_res <= '{cls: r_c, slot: s_new, count: cnt_new, opened: r_opened,
                       status: ecb_pkg::ST_OK};
        end else if (i_ctl.rm_wr) begin
            r_res <= '{cls: r_oldc, slot: r_olds, count: cnt_rm, opened: 1'b0,
                       status: ecb_pkg::ST_OK};
        end else begin
            r_res <= r_res;
        end
        if (i_ctl.out_load) begin
            r_out <= r_res;
        end
    end

    always_comb begin
        o_stat.clr_last = (r_clr_idx == ecb_pkg::ATOM_W'(ecb_pkg::NUM_SITES - 1));
        o_stat.cmd      = r_cmd;
        o_stat.rng_bad  = r_rng_bad;
        o_stat.present  = (acp_rdata != '0);
        o_stat.match    = (e_x > lo) && (e_x <= hi);
        o_stat.srch_end = (r_idx == r_ciu);
        o_stat.full     = (r_ciu == ecb_pkg::CIU_W'(ecb_pkg::MAX_CLASSES));
        o_stat.out_free = !r_out_valid || i_ready;
    end

    assign o_valid       = r_out_valid;
    assign o_class_index = 5'(r_out.cls);
    assign o_slot_index  = 10'(r_out.slot);
    assign o_class_count = 11'(r_out.count);
    assign o_new_class   = r_out.opened;
    assign o_status      = r_out.status;

`ifndef SYNTH
    a_ciu_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ciu <= ecb_pkg::CIU_W'(ecb_pkg::MAX_CLASSES))
        else $error("class count beyond table size");

    a_open_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.miss |-> (r_ciu < ecb_pkg::CIU_W'(ecb_pkg::MAX_CLASSES)))
        else $error("new class opened in a full table");

    a_add_open_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.add_wr |-> (ecb_pkg::CIU_W'(r_c) < r_ciu))
        else $error("append into a class that is not open");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.out_load |-> (!r_out_valid || i_ready))
        else $error("result register overwritten");
`endif

endmodule

// ----- hw/rtl/ecb_ctrl.sv -----
module ecb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ecb_pkg::t_stat i_stat,
    output ecb_pkg::t_ctl  o_ctl
);

    ecb_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ecb_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_ctl          = '0;
        o_ctl.err_code = ecb_pkg::ST_OK;
        o_ready        = 1'b0;
        unique case (r_state)
            ecb_pkg::S_CLEAR: begin
                o_ctl.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ecb_pkg::S_IDLE;
                end
            end
            ecb_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_ctl.take = 1'b1;
                    n_state    = ecb_pkg::S_WAIT;
                end
            end
            ecb_pkg::S_WAIT: begin
                n_state = ecb_pkg::S_CHK;
            end
            ecb_pkg::S_CHK: begin
                o_ctl.chk = 1'b1;
                priority if (i_stat.cmd == ecb_pkg::CMD_NOP) begin
                    o_ctl.res_zero = 1'b1;
                    n_state        = ecb_pkg::S_DONE;
                end else if (i_stat.rng_bad) begin
                    o_ctl.res_err  = 1'b1;
                    o_ctl.err_code = ecb_pkg::ST_OUT_OF_RANGE;
                    n_state        = ecb_pkg::S_DONE;
                end else if (i_stat.cmd == ecb_pkg::CMD_INSERT && i_stat.present) begin
                    o_ctl.res_err  = 1'b1;
                    o_ctl.err_code = ecb_pkg::ST_ALREADY;
                    n_state        = ecb_pkg::S_DONE;
                end else if (i_stat.cmd != ecb_pkg::CMD_INSERT && !i_stat.present) begin
                    o_ctl.res_err  = 1'b1;
                    o_ctl.err_code = ecb_pkg::ST_NOT_PRESENT;
                    n_state        = ecb_pkg::S_DONE;
                end else if (i_stat.cmd == ecb_pkg::CMD_DELETE) begin
                    n_state = ecb_pkg::S_REM_A;
                end else begin
                    o_ctl.srch_start = 1'b1;
                    n_state          = ecb_pkg::S_SRCH_RD;
                end
            end
            ecb_pkg::S_SRCH_RD: begin
                priority if (i_stat.srch_end && i_stat.full) begin
                    o_ctl.res_err  = 1'b1;
                    o_ctl.err_code = ecb_pkg::ST_TABLE_FULL;
                    n_state        = ecb_pkg::S_DONE;
                end else if (i_stat.srch_end) begin
                    o_ctl.miss = 1'b1;
                    n_state    = (i_stat.cmd == ecb_pkg::CMD_MOVE) ?
                                 ecb_pkg::S_REM_A : ecb_pkg::S_ADD_A;
                end else begin
                    n_state = ecb_pkg::S_SRCH_CMP;
                end
            end
            ecb_pkg::S_SRCH_CMP: begin
                if (i_stat.match) begin
                    o_ctl.hit = 1'b1;
                    n_state   = (i_stat.cmd == ecb_pkg::CMD_MOVE) ?
                                ecb_pkg::S_REM_A : ecb_pkg::S_ADD_A;
                end else begin
                    o_ctl.srch_next = 1'b1;
                    n_state         = ecb_pkg::S_SRCH_RD;
                end
            end
            ecb_pkg::S_REM_A: begin
                n_state = ecb_pkg::S_REM_B;
            end
            ecb_pkg::S_REM_B: begin
                o_ctl.rm_rd_last = 1'b1;
                n_state          = ecb_pkg::S_REM_C;
            end
            ecb_pkg::S_REM_C: begin
                o_ctl.rm_wr = 1'b1;
                n_state     = (i_stat.cmd == ecb_pkg::CMD_MOVE) ?
                              ecb_pkg::S_ADD_A : ecb_pkg::S_DONE;
            end
            ecb_pkg::S_ADD_A: begin
                o_ctl.sz_sel_new = 1'b1;
                n_state          = ecb_pkg::S_ADD_B;
            end
            ecb_pkg::S_ADD_B: begin
                o_ctl.add_wr = 1'b1;
                n_state      = ecb_pkg::S_DONE;
            end
            ecb_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = ecb_pkg::S_IDLE;
                end
            end
            default: n_state = ecb_pkg::S_IDLE;
        endcase
    end

`ifndef SYNTH
    a_take_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.take |=> (r_state == ecb_pkg::S_WAIT))
        else $error("word taken outside idle");

    a_single_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_ctl.rm_wr, o_ctl.add_wr, o_ctl.clr_step}))
        else $error("two table updates in one cycle");

    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ecb_pkg::S_CLEAR) |-> !o_ready)
        else $error("input open during clear pass");
`endif

endmodule

// ----- hw/rtl/energy_class_bucket_table.sv -----
// Energy class bucket table: sites join energy classes (window above class energy minus
// tolerance up to class energy plus tolerance, first match wins) through insert, move and
// delete commands, one word at a time. After reset a clearing pass empties the site map
// before the first word is taken. An insert or a move searches the classes in order and
// opens a new class when none matches (up to 32 classes; a full table is reported only
// after the search finds no match): the class search reads one stored class energy from
// its memory at a time, and each table update is a read-modify-write through memories
// with a registered read. The result waits in an output register.
module energy_class_bucket_table_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ecb_pkg::CFG_IW-1:0]       i_cfg_index,
    input  logic [ecb_pkg::CFG_DW-1:0]       i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [1:0]                       i_cmd,
    input  logic [15:0]                      i_site_number,
    input  logic signed [15:0]               i_site_energy,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [4:0]                       o_class_index,
    output logic [9:0]                       o_slot_index,
    output logic [10:0]                      o_class_count,
    output logic                             o_new_class,
    output logic [2:0]                       o_status
);

    ecb_pkg::t_ctl  ctl;
    ecb_pkg::t_stat stat;

    ecb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

    ecb_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (i_cmd),
        .i_site_number (i_site_number),
        .i_site_energy (i_site_energy),
        .i_ctl         (ctl),
        .o_stat        (stat),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_class_index (o_class_index),
        .o_slot_index  (o_slot_index),
        .o_class_count (o_class_count),
        .o_new_class   (o_new_class),
        .o_status      (o_status)
    );

endmodule
